/* design/sws_pkg.sv */
// Shared types, constants and byte helpers for the sentence whole-word search.
`timescale 1ns / 1ps

package sws_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int WORD_REGS   = 4;
    localparam int LEN_W       = 6;

    // word storage and default chain length
    localparam int WORD_BYTES_MAX   = 32;
    localparam int DEFAULT_MAX_WORD = 32;

    // result field widths
    localparam int OFFSET_W = 32;
    localparam int COUNT_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WORD_LENGTH  = 3'd0,
        REG_WORD_BYTES_0 = 3'd1,
        REG_WORD_BYTES_1 = 3'd2,
        REG_WORD_BYTES_2 = 3'd3,
        REG_WORD_BYTES_3 = 3'd4
    } cfg_reg_t;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_QUEST = 8'h3F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

    typedef struct packed {
        logic blank;
        logic alnum;
        logic closes;
        logic eot;
    } byte_class_t;

    typedef struct packed {
        logic                sentence_valid;
        logic                contains_word;
        logic [COUNT_W-1:0]  sentence_index;
        logic [OFFSET_W-1:0] start_offset;
        logic [OFFSET_W-1:0] end_offset;
        logic [COUNT_W-1:0]  found_count;
        logic                text_done;
    } result_t;

    // ASCII lower-casing
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic upper;
        upper = (c >= 8'h41) && (c <= 8'h5A);
        return upper ? (c + 8'h20) : c;
    endfunction

    function automatic byte_class_t classify(input logic [7:0] c, input logic eot);
        byte_class_t k;
        k.blank  = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
        k.alnum  = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A))
                || ((c >= 8'h61) && (c <= 8'h7A));
        k.closes = (c == CHAR_DOT) || (c == CHAR_BANG) || (c == CHAR_QUEST) || eot;
        k.eot    = eot;
        return k;
    endfunction

endpackage

/* design/sws_if.sv */
// Valid/ready channel interfaces for text bytes and sentence results.
`timescale 1ns / 1ps

interface sws_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sws_result_if;
    logic        valid;
    logic        ready;
    logic        sentence_valid;
    logic        contains_word;
    logic [15:0] sentence_index;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic [15:0] found_count;
    logic        text_done;

    modport source (output valid, output sentence_valid, output contains_word,
                    output sentence_index, output start_offset, output end_offset,
                    output found_count, output text_done, input ready);
    modport sink   (input valid, input sentence_valid, input contains_word,
                    input sentence_index, input start_offset, input end_offset,
                    input found_count, input text_done, output ready);
endinterface

/* design/sws_cell.sv */
// One compare cell of the partial-match chain.
`timescale 1ns / 1ps

module sws_cell
    import sws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       clear,
    input  logic [7:0] text_fold,
    input  logic [7:0] word_byte,
    input  logic       link_in,
    output logic       match_now,
    output logic       link_out
);

    logic held_reg;
    logic held_next;

    // word bytes 0..j match the last j+1 text bytes
    assign match_now = link_in && (fold(word_byte) == text_fold);

    always_comb
    begin
        held_next = held_reg;
        if (advance)
        begin
            held_next = match_now && !clear;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    assign link_out = held_reg;

endmodule

/* design/sws_track.sv */
// Sentence tracker: trim bounds, match confirmation, counters and result build.
`timescale 1ns / 1ps

module sws_track
    import sws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  byte_class_t cls,
    input  logic        hit,
    output logic        start_ok,
    output logic        push,
    output result_t     res
);

    logic                word_seen_reg, word_seen_next;
    logic                tail_reg, tail_next;
    logic                pend_reg, pend_next;
    logic                has_nb_reg, has_nb_next;
    logic [OFFSET_W-1:0] first_reg, first_next;
    logic [OFFSET_W-1:0] last_reg, last_next;
    logic [OFFSET_W-1:0] pos_reg, pos_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  found_reg, found_next;
    logic                prev_blank_reg, prev_blank_next;
    logic                prev_alnum_reg, prev_alnum_next;

    logic                seen;
    logic                tail;
    logic                pend;
    logic                has_nb;
    logic [OFFSET_W-1:0] first;
    logic [OFFSET_W-1:0] last;
    logic [COUNT_W-1:0]  found_upd;

    // a match may start on this byte: inside the trimmed sentence, left side clear
    assign start_ok = has_nb && (!has_nb_reg || !prev_alnum_reg);

    always_comb
    begin
        seen = word_seen_reg;
        tail = tail_reg;
        pend = 1'b0;
        // match that ended in a blank counts once a non-blank follows
        if (tail && !cls.blank)
        begin
            seen = 1'b1;
            tail = 1'b0;
        end
        // right-hand check of a match that ended on the previous byte
        if (pend_reg && !cls.alnum)
        begin
            if (!prev_blank_reg || !cls.blank)
            begin
                seen = 1'b1;
            end
            else
            begin
                tail = 1'b1;
            end
        end

        has_nb = has_nb_reg || !cls.blank;
        first  = (!has_nb_reg && !cls.blank) ? pos_reg : first_reg;
        last   = !cls.blank ? pos_reg : last_reg;

        if (hit)
        begin
            if (cls.closes)
            begin
                if (!cls.blank)
                begin
                    seen = 1'b1;
                end
            end
            else
            begin
                pend = 1'b1;
            end
        end

        found_upd = found_reg;
        if (has_nb && seen && (found_reg != COUNT_MAX))
        begin
            found_upd = found_reg + 1'b1;
        end

        push               = cls.closes && (has_nb || cls.eot);
        res.sentence_valid = has_nb;
        res.contains_word  = has_nb && seen;
        res.sentence_index = count_reg;
        res.start_offset   = has_nb ? first : '0;
        res.end_offset     = has_nb ? last : '0;
        res.found_count    = found_upd;
        res.text_done      = cls.eot;

        word_seen_next  = word_seen_reg;
        tail_next       = tail_reg;
        pend_next       = pend_reg;
        has_nb_next     = has_nb_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        prev_blank_next = prev_blank_reg;
        prev_alnum_next = prev_alnum_reg;

        if (advance)
        begin
            prev_blank_next = cls.blank;
            prev_alnum_next = cls.alnum;
            if (cls.closes)
            begin
                word_seen_next = 1'b0;
                tail_next      = 1'b0;
                pend_next      = 1'b0;
                has_nb_next    = 1'b0;
                first_next     = '0;
                last_next      = '0;
                found_next     = found_upd;
                if (has_nb && (count_reg != COUNT_MAX))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                word_seen_next = seen;
                tail_next      = tail;
                pend_next      = pend;
                has_nb_next    = has_nb;
                first_next     = first;
                last_next      = last;
            end

            if (cls.eot)
            begin
                pos_next   = '0;
                count_next = '0;
                found_next = '0;
            end
            else if (pos_reg != OFFSET_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_seen_reg  <= 1'b0;
            tail_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            has_nb_reg     <= 1'b0;
            first_reg      <= '0;
            last_reg       <= '0;
            pos_reg        <= '0;
            count_reg      <= '0;
            found_reg      <= '0;
            prev_blank_reg <= 1'b0;
            prev_alnum_reg <= 1'b0;
        end
        else
        begin
            word_seen_reg  <= word_seen_next;
            tail_reg       <= tail_next;
            pend_reg       <= pend_next;
            has_nb_reg     <= has_nb_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            found_reg      <= found_next;
            prev_blank_reg <= prev_blank_next;
            prev_alnum_reg <= prev_alnum_next;
        end
    end

endmodule

/* design/sentence_whole_word_search.sv */
// Top level of the per-sentence case-insensitive whole-word search.
// A closing byte's result is registered in the output register, or else in the skid entry.
// Throughput: one text byte per cycle; each byte makes one pass through the cell chain.
// Output register plus skid entry; text is stalled only while both hold results.
// Reset: counters, chain and queue cleared, word_length 1, word bytes 0; no clearing pass.
`timescale 1ns / 1ps

module sentence_whole_word_search
    import sws_pkg::*;
#(
    parameter int MAX_WORD = DEFAULT_MAX_WORD
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    sws_text_if.sink               text,
    sws_result_if.source           report
);

    localparam int IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    // ---------------------------------------------------------------
    // Configuration: word bytes, and the word length held as the index
    // of the last chain cell (0 taken as 1, clipped to MAX_WORD)
    // ---------------------------------------------------------------
    logic [WORD_REGS-1:0][CFG_DATA_W-1:0] word_reg;
    logic [IDX_W-1:0]                     len_idx_reg;
    logic [LEN_W-1:0]                     len_raw;
    logic [IDX_W-1:0]                     len_idx_wr;

    assign len_raw = cfg_data[LEN_W-1:0];

    always_comb
    begin
        if (len_raw == '0)
        begin
            len_idx_wr = '0;
        end
        else if ({1'b0, len_raw} > (LEN_W+1)'(MAX_WORD))
        begin
            len_idx_wr = IDX_W'(MAX_WORD - 1);
        end
        else
        begin
            len_idx_wr = IDX_W'(len_raw - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg    <= '0;
            len_idx_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WORD_LENGTH:  len_idx_reg <= len_idx_wr;
                REG_WORD_BYTES_0: word_reg[0] <= cfg_data;
                REG_WORD_BYTES_1: word_reg[1] <= cfg_data;
                REG_WORD_BYTES_2: word_reg[2] <= cfg_data;
                REG_WORD_BYTES_3: word_reg[3] <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input byte: fold and classify once, broadcast to all cells
    // ---------------------------------------------------------------
    logic        advance;
    logic [7:0]  text_fold;
    byte_class_t cls;

    assign advance   = text.valid && text.ready;
    assign text_fold = fold(text.text_byte);
    assign cls       = classify(text.text_byte, text.end_of_text);

    // ---------------------------------------------------------------
    // Cell chain: cell j holds "word bytes 0..j matched, ending on the
    // previous byte" and hands it to cell j+1 on every taken byte.
    // Cell 0 is seeded by the tracker's left-boundary check.
    // ---------------------------------------------------------------
    logic                         start_ok;
    logic [MAX_WORD-1:0]          match_now;
    logic [MAX_WORD:0]            link;
    logic [WORD_BYTES_MAX*8-1:0]  word_flat;
    logic                         hit;

    assign word_flat = word_reg;
    assign link[0]   = start_ok;

    for (genvar j = 0; j < MAX_WORD; j++)
    begin : g_cell
        sws_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .clear     (cls.closes),
            .text_fold (text_fold),
            .word_byte (word_flat[8*j +: 8]),
            .link_in   (link[j]),
            .match_now (match_now[j]),
            .link_out  (link[j+1])
        );
    end

    // full word matched on this byte, left side already checked
    assign hit = match_now[len_idx_reg];

    // ---------------------------------------------------------------
    // Sentence tracker
    // ---------------------------------------------------------------
    logic    res_push;
    result_t res;

    sws_track u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cls      (cls),
        .hit      (hit),
        .start_ok (start_ok),
        .push     (res_push),
        .res      (res)
    );

    // ---------------------------------------------------------------
    // Result queue: output register and one skid entry. Text is taken
    // whenever the skid entry is free, so a waiting result never stalls
    // the byte stream by itself.
    // ---------------------------------------------------------------
    logic    push;
    logic    pop;
    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    assign text.ready = !skid_valid_reg;
    assign push       = advance && res_push;
    assign pop        = out_valid_reg && report.ready;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign report.valid          = out_valid_reg;
    assign report.sentence_valid = out_reg.sentence_valid;
    assign report.contains_word  = out_reg.contains_word;
    assign report.sentence_index = out_reg.sentence_index;
    assign report.start_offset   = out_reg.start_offset;
    assign report.end_offset     = out_reg.end_offset;
    assign report.found_count    = out_reg.found_count;
    assign report.text_done      = out_reg.text_done;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------

    // skid entry only fills behind a held output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // a result for a blank sentence only comes from the final byte
    a_blank_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !res.sentence_valid) |-> res.text_done)
        else $error("blank-sentence result without end of text");

    // a sentence said to hold the word has a valid, ordered span
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res.contains_word) |-> (res.sentence_valid
            && (res.start_offset <= res.end_offset)))
        else $error("word found in a sentence with a bad span");

    // with no stall downstream, the byte stream is never held off
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && report.ready) |=> text.ready)
        else $error("text stalled after the output drained");

endmodule
